@@ src/assert_macros.svh @@
// Assertion macros for the checker file of the instruction decoder.
// Depends on nothing; included by name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/rv64d_pkg.sv @@
// Shared types and constants of the RV64IM instruction decoder.
// Depends on nothing; used by the decode, counter and top-level modules.
package rv64d_pkg;

   // Register file size and use counter width.
   localparam int NUM_REGS    = 32;
   localparam int REG_IDX_W   = 5;
   localparam int COUNT_WIDTH = 32;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // Request stream layout: instruction, then counter index, padded to bytes.
   localparam int REQ_INSTR_LSB = 0;
   localparam int REQ_INDEX_LSB = 32;
   localparam int REQ_DATA_W    = 40;

   // Response stream layout, lowest field first, padded to bytes.
   localparam int RSP_CLASS_LSB = 0;
   localparam int RSP_MNEM_LSB  = 3;
   localparam int RSP_RD_LSB    = 10;
   localparam int RSP_RS1_LSB   = 15;
   localparam int RSP_RS2_LSB   = 20;
   localparam int RSP_IMM_LSB   = 25;
   localparam int RSP_COUNT_LSB = 57;
   localparam int RSP_DATA_W    = 96;

   // Major opcodes, taken from instruction bits 6..2.
   typedef enum logic [4:0] {
      OPC_LOAD       = 5'h00,
      OPC_MISC_MEM   = 5'h03,
      OPC_OP_IMM     = 5'h04,
      OPC_AUIPC      = 5'h05,
      OPC_OP_IMM_32  = 5'h06,
      OPC_STORE      = 5'h08,
      OPC_OP         = 5'h0c,
      OPC_LUI        = 5'h0d,
      OPC_OP_32      = 5'h0e,
      OPC_BRANCH     = 5'h18,
      OPC_JALR       = 5'h19,
      OPC_JAL        = 5'h1b,
      OPC_SYSTEM     = 5'h1c
   } opcode_type;

   // Operation classes reported on the response.
   typedef enum logic [2:0] {
      CL_UPPER,
      CL_IMM,
      CL_JUMP,
      CL_SYS,
      CL_BRANCH,
      CL_STORE,
      CL_REGREG
   } class_type;

   // Dense mnemonic codes, numbered in decode order.
   typedef enum logic [6:0] {
      MN_LUI, MN_AUIPC, MN_JAL, MN_JALR, MN_FENCE, MN_FENCE_I,
      MN_BEQ, MN_BNE, MN_BLT, MN_BGE, MN_BLTU, MN_BGEU,
      MN_LB, MN_LH, MN_LW, MN_LD, MN_LBU, MN_LHU, MN_LWU,
      MN_SB, MN_SH, MN_SW, MN_SD,
      MN_MUL, MN_MULH, MN_MULHSU, MN_MULHU, MN_DIV, MN_DIVU, MN_REM, MN_REMU,
      MN_ADD, MN_SUB, MN_SLL, MN_SLT, MN_SLTU, MN_XOR, MN_SRL, MN_SRA, MN_OR, MN_AND,
      MN_ECALL, MN_EBREAK,
      MN_CSRRW, MN_CSRRS, MN_CSRRC, MN_CSRRWI, MN_CSRRSI, MN_CSRRCI,
      MN_ADDIW, MN_SLLIW, MN_SRLIW, MN_SRAIW,
      MN_MULW, MN_DIVW, MN_DIVUW, MN_REMW, MN_REMUW,
      MN_ADDW, MN_SUBW, MN_SLLW, MN_SRLW, MN_SRAW,
      MN_ADDI, MN_SLLI, MN_SLTI, MN_SLTIU, MN_XORI, MN_SRLI, MN_SRAI, MN_ORI, MN_ANDI
   } mnem_type;

   // Decoded form of one instruction word.
   typedef struct packed {
      class_type              op_class;
      mnem_type               mnemonic;
      logic [REG_IDX_W-1:0]   dest_reg;
      logic [REG_IDX_W-1:0]   src1_reg;
      logic [REG_IDX_W-1:0]   src2_reg;
      logic [31:0]            immediate;
      logic                   illegal;
      logic                   use_rd;
      logic                   use_rs1;
      logic                   use_rs2;
   } dec_type;

   // Counter update request for one decoded instruction.
   typedef struct packed {
      logic                   en;
      logic [REG_IDX_W-1:0]   rd;
      logic [REG_IDX_W-1:0]   rs1;
      logic [REG_IDX_W-1:0]   rs2;
      logic                   use_rd;
      logic                   use_rs1;
      logic                   use_rs2;
   } use_type;

   // Use counter as reported on the 32-bit response field.
   function automatic logic [31:0] count_to_field(input logic [COUNT_WIDTH-1:0] cnt);
      logic [COUNT_WIDTH+31:0] ext;
      ext = {32'b0, cnt};
      return ext[31:0];
   endfunction

endpackage

@@ src/rv64d_decode.sv @@
// Combinational decode of one RV64IM instruction word into its fields.
// Depends on rv64d_pkg for the opcode, class and mnemonic codes.
module rv64d_decode (
   input  logic [31:0]        instruction,
   output rv64d_pkg::dec_type dec
);

   logic [2:0]  f3;
   logic        b30;
   logic        b25;
   logic [31:0] imm_i;
   logic [31:0] imm_s;
   logic [31:0] imm_b;
   logic [31:0] imm_u;
   logic [31:0] imm_j;
   logic [31:0] shamt6;
   logic [31:0] shamt5;
   logic [4:0]  rs2;

   // Field extraction and the immediate layouts of each format.
   assign f3     = instruction[14:12];
   assign b30    = instruction[30];
   assign b25    = instruction[25];
   assign rs2    = instruction[24:20];
   assign imm_i  = {{20{instruction[31]}}, instruction[31:20]};
   assign imm_s  = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
   assign imm_b  = {{19{instruction[31]}}, instruction[31], instruction[7],
                    instruction[30:25], instruction[11:8], 1'b0};
   assign imm_u  = {instruction[31:12], 12'b0};
   assign imm_j  = {{11{instruction[31]}}, instruction[31], instruction[19:12],
                    instruction[20], instruction[30:21], 1'b0};
   assign shamt6 = {26'b0, instruction[25:20]};
   assign shamt5 = {27'b0, instruction[24:20]};

   // Opcode decode; only bits 6..2 select the major opcode.
   always_comb begin
      dec           = '0;
      dec.dest_reg  = instruction[11:7];
      dec.src1_reg  = instruction[19:15];
      dec.op_class  = rv64d_pkg::CL_UPPER;
      dec.mnemonic  = rv64d_pkg::MN_LUI;
      unique case (rv64d_pkg::opcode_type'(instruction[6:2]))
         rv64d_pkg::OPC_LUI: begin
            dec.op_class  = rv64d_pkg::CL_UPPER;
            dec.mnemonic  = rv64d_pkg::MN_LUI;
            dec.immediate = imm_u;
            dec.use_rd    = 1'b1;
         end
         rv64d_pkg::OPC_AUIPC: begin
            dec.op_class  = rv64d_pkg::CL_IMM;
            dec.mnemonic  = rv64d_pkg::MN_AUIPC;
            dec.immediate = imm_u;
            dec.use_rd    = 1'b1;
         end
         rv64d_pkg::OPC_JAL: begin
            dec.op_class  = rv64d_pkg::CL_JUMP;
            dec.mnemonic  = rv64d_pkg::MN_JAL;
            dec.immediate = imm_j;
            dec.use_rd    = 1'b1;
         end
         rv64d_pkg::OPC_JALR: begin
            dec.op_class  = rv64d_pkg::CL_JUMP;
            dec.mnemonic  = rv64d_pkg::MN_JALR;
            dec.immediate = imm_i;
            dec.use_rd    = 1'b1;
            dec.use_rs1   = 1'b1;
         end
         rv64d_pkg::OPC_MISC_MEM: begin
            // Fences read no register fields.
            dec.op_class  = rv64d_pkg::CL_SYS;
            dec.immediate = imm_i;
            if (f3 <= 3'd1) begin
               dec.mnemonic = rv64d_pkg::mnem_type'(7'(rv64d_pkg::MN_FENCE) + {4'b0, f3});
            end else begin
               dec.illegal = 1'b1;
            end
         end
         rv64d_pkg::OPC_BRANCH: begin
            dec.op_class  = rv64d_pkg::CL_BRANCH;
            dec.src2_reg  = rs2;
            dec.immediate = imm_b;
            dec.use_rs1   = 1'b1;
            dec.use_rs2   = 1'b1;
            if (f3 == 3'd2 || f3 == 3'd3) begin
               dec.illegal = 1'b1;
            end else if (f3 < 3'd2) begin
               dec.mnemonic = rv64d_pkg::mnem_type'(7'(rv64d_pkg::MN_BEQ) + {4'b0, f3});
            end else begin
               dec.mnemonic = rv64d_pkg::mnem_type'(7'(rv64d_pkg::MN_BLT) + {4'b0, f3} - 7'd4);
            end
         end
         rv64d_pkg::OPC_LOAD: begin
            dec.op_class  = rv64d_pkg::CL_IMM;
            dec.immediate = imm_i;
            dec.use_rd    = 1'b1;
            dec.use_rs1   = 1'b1;
            if (f3 == 3'd7) begin
               dec.illegal = 1'b1;
            end else begin
               dec.mnemonic = rv64d_pkg::mnem_type'(7'(rv64d_pkg::MN_LB) + {4'b0, f3});
            end
         end
         rv64d_pkg::OPC_STORE: begin
            dec.op_class  = rv64d_pkg::CL_STORE;
            dec.src2_reg  = rs2;
            dec.immediate = imm_s;
            dec.use_rs1   = 1'b1;
            dec.use_rs2   = 1'b1;
            if (f3 > 3'd3) begin
               dec.illegal = 1'b1;
            end else begin
               dec.mnemonic = rv64d_pkg::mnem_type'(7'(rv64d_pkg::MN_SB) + {4'b0, f3});
            end
         end
         rv64d_pkg::OPC_OP: begin
            dec.op_class = rv64d_pkg::CL_REGREG;
            dec.src2_reg = rs2;
            dec.use_rd   = 1'b1;
            dec.use_rs1  = 1'b1;
            dec.use_rs2  = 1'b1;
            if (b25) begin
               // Multiply and divide extension.
               dec.mnemonic = rv64d_pkg::mnem_type'(7'(rv64d_pkg::MN_MUL) + {4'b0, f3});
            end else begin
               case (f3)
                  3'd0:    dec.mnemonic = b30 ? rv64d_pkg::MN_SUB : rv64d_pkg::MN_ADD;
                  3'd1:    dec.mnemonic = rv64d_pkg::MN_SLL;
                  3'd2:    dec.mnemonic = rv64d_pkg::MN_SLT;
                  3'd3:    dec.mnemonic = rv64d_pkg::MN_SLTU;
                  3'd4:    dec.mnemonic = rv64d_pkg::MN_XOR;
                  3'd5:    dec.mnemonic = b30 ? rv64d_pkg::MN_SRA : rv64d_pkg::MN_SRL;
                  3'd6:    dec.mnemonic = rv64d_pkg::MN_OR;
                  default: dec.mnemonic = rv64d_pkg::MN_AND;
               endcase
            end
         end
         rv64d_pkg::OPC_SYSTEM: begin
            dec.op_class  = rv64d_pkg::CL_SYS;
            dec.immediate = imm_i;
            dec.use_rd    = 1'b1;
            if (f3 == 3'd0) begin
               dec.mnemonic = instruction[20] ? rv64d_pkg::MN_EBREAK : rv64d_pkg::MN_ECALL;
            end else if (f3 <= 3'd3) begin
               // Register forms of the CSR accesses read rs1.
               dec.mnemonic = rv64d_pkg::mnem_type'(7'(rv64d_pkg::MN_CSRRW) + {4'b0, f3} - 7'd1);
               dec.use_rs1  = 1'b1;
            end else if (f3 == 3'd4) begin
               dec.illegal = 1'b1;
            end else begin
               dec.mnemonic = rv64d_pkg::mnem_type'(7'(rv64d_pkg::MN_CSRRWI) + {4'b0, f3} - 7'd5);
            end
         end
         rv64d_pkg::OPC_OP_IMM_32: begin
            dec.op_class = rv64d_pkg::CL_IMM;
            dec.use_rd   = 1'b1;
            dec.use_rs1  = 1'b1;
            case (f3)
               3'd0: begin
                  dec.mnemonic  = rv64d_pkg::MN_ADDIW;
                  dec.immediate = imm_i;
               end
               3'd1: begin
                  dec.mnemonic  = rv64d_pkg::MN_SLLIW;
                  dec.immediate = shamt5;
               end
               3'd5: begin
                  dec.mnemonic  = b30 ? rv64d_pkg::MN_SRAIW : rv64d_pkg::MN_SRLIW;
                  dec.immediate = shamt5;
               end
               default: dec.illegal = 1'b1;
            endcase
         end
         rv64d_pkg::OPC_OP_32: begin
            dec.op_class = rv64d_pkg::CL_REGREG;
            dec.src2_reg = rs2;
            dec.use_rd   = 1'b1;
            dec.use_rs1  = 1'b1;
            dec.use_rs2  = 1'b1;
            if (b25) begin
               if (f3 == 3'd0) begin
                  dec.mnemonic = rv64d_pkg::MN_MULW;
               end else if (f3 >= 3'd4) begin
                  dec.mnemonic = rv64d_pkg::mnem_type'(7'(rv64d_pkg::MN_DIVW) + {4'b0, f3} - 7'd4);
               end else begin
                  dec.illegal = 1'b1;
               end
            end else begin
               case (f3)
                  3'd0:    dec.mnemonic = b30 ? rv64d_pkg::MN_SUBW : rv64d_pkg::MN_ADDW;
                  3'd1:    dec.mnemonic = rv64d_pkg::MN_SLLW;
                  3'd5:    dec.mnemonic = b30 ? rv64d_pkg::MN_SRAW : rv64d_pkg::MN_SRLW;
                  default: dec.illegal  = 1'b1;
               endcase
            end
         end
         rv64d_pkg::OPC_OP_IMM: begin
            dec.op_class  = rv64d_pkg::CL_IMM;
            dec.immediate = imm_i;
            dec.use_rd    = 1'b1;
            dec.use_rs1   = 1'b1;
            case (f3)
               3'd0: dec.mnemonic = rv64d_pkg::MN_ADDI;
               3'd1: begin
                  dec.mnemonic  = rv64d_pkg::MN_SLLI;
                  dec.immediate = shamt6;
               end
               3'd2: dec.mnemonic = rv64d_pkg::MN_SLTI;
               3'd3: dec.mnemonic = rv64d_pkg::MN_SLTIU;
               3'd4: dec.mnemonic = rv64d_pkg::MN_XORI;
               3'd5: begin
                  dec.mnemonic  = b30 ? rv64d_pkg::MN_SRAI : rv64d_pkg::MN_SRLI;
                  dec.immediate = shamt6;
               end
               3'd6:    dec.mnemonic = rv64d_pkg::MN_ORI;
               default: dec.mnemonic = rv64d_pkg::MN_ANDI;
            endcase
         end
         default: dec.illegal = 1'b1;
      endcase
   end

endmodule

@@ src/rv64d_use_counters.sv @@
// Bank of saturating per-register use counters with one read port.
// Depends on rv64d_pkg for the counter width and the update record.
module rv64d_use_counters (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rv64d_pkg::use_type                    upd,
   input  logic [rv64d_pkg::REG_IDX_W-1:0]       read_index,
   output logic [rv64d_pkg::COUNT_WIDTH-1:0]     read_count
);

   logic [rv64d_pkg::COUNT_WIDTH-1:0] cnt_ff [rv64d_pkg::NUM_REGS];
   logic [rv64d_pkg::COUNT_WIDTH-1:0] cnt_in [rv64d_pkg::NUM_REGS];

   // Each counter adds up to three hits from one instruction and saturates.
   always_comb begin
      logic [1:0]                          inc;
      logic [rv64d_pkg::COUNT_WIDTH+1:0]   sum;
      for (int i = 0; i < rv64d_pkg::NUM_REGS; i++) begin
         inc = 2'({1'b0, upd.use_rd  && upd.rd  == rv64d_pkg::REG_IDX_W'(i)})
             + 2'({1'b0, upd.use_rs1 && upd.rs1 == rv64d_pkg::REG_IDX_W'(i)})
             + 2'({1'b0, upd.use_rs2 && upd.rs2 == rv64d_pkg::REG_IDX_W'(i)});
         sum = (rv64d_pkg::COUNT_WIDTH+2)'(cnt_ff[i]) + (rv64d_pkg::COUNT_WIDTH+2)'(inc);
         if (!upd.en) begin
            cnt_in[i] = cnt_ff[i];
         end else if (sum > (rv64d_pkg::COUNT_WIDTH+2)'(rv64d_pkg::COUNT_MAX)) begin
            cnt_in[i] = rv64d_pkg::COUNT_MAX;
         end else begin
            cnt_in[i] = sum[rv64d_pkg::COUNT_WIDTH-1:0];
         end
      end
   end

   // Counter registers, cleared by reset.
   always_ff @(posedge clock) begin
      for (int i = 0; i < rv64d_pkg::NUM_REGS; i++) begin
         if (reset) begin
            cnt_ff[i] <= '0;
         end else begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   assign read_count = cnt_ff[read_index];

endmodule

@@ src/rv64im_instruction_decoder.sv @@
// Top level of the RV64IM instruction decoder with register use counters.
// Depends on rv64d_pkg, rv64d_decode and rv64d_use_counters.
//
// Usage:
//   The req channel carries one item per transfer: req_tuser selects the
//   mode (0 decode the instruction word, 1 read one register use counter),
//   and req_tdata holds the instruction word and the counter index.
//   The rsp channel returns exactly one result per request, in order: the
//   class, mnemonic, register numbers, immediate and counter value in
//   rsp_tdata, and the illegal-encoding flag in rsp_tuser.
//   A request is captured in the input register, decoded and counted, and
//   then held in the result register, which drives rsp_tvalid.
//   Throughput is one item per cycle while the receiver does not stall;
//   the decode between those registers is a single pass of logic and each
//   counter updates in the same cycle.
//   A counter read sees the updates of every decode accepted before it.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more item; req_tready drops only when both
//   are full.
//   Synchronous reset empties both registers and clears all 32 counters.
module rv64im_instruction_decoder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // instruction [31:0], counter_index [36:32], zero [39:37]
   input  logic [rv64d_pkg::REQ_DATA_W-1:0]  req_tdata,
   // mode [0]
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // op_class [2:0], mnemonic [9:3], dest_reg [14:10], src1_reg [19:15],
   // src2_reg [24:20], immediate [56:25], count_value [88:57], zero [95:89]
   output logic [rv64d_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // illegal [0]
   output logic                              rsp_tuser
);

   logic                                   s1_valid_ff;
   logic                                   s1_mode_ff;
   logic [31:0]                            s1_instr_ff;
   logic [rv64d_pkg::REG_IDX_W-1:0]        s1_index_ff;
   logic                                   rsp_valid_ff;
   logic [rv64d_pkg::RSP_DATA_W-1:0]       rsp_data_ff;
   logic [rv64d_pkg::RSP_DATA_W-1:0]       rsp_data_in;
   logic                                   rsp_user_ff;
   logic                                   rsp_user_in;
   logic                                   advance;
   logic                                   req_xfer;
   rv64d_pkg::dec_type                     dec;
   rv64d_pkg::use_type                     upd;
   logic [rv64d_pkg::COUNT_WIDTH-1:0]      read_count;

   // Handshake: the input stage moves on whenever the result register is free.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   rv64d_decode u_decode (
      .instruction (s1_instr_ff),
      .dec         (dec)
   );

   // Count register uses of a legal decode as it moves into the result register.
   always_comb begin
      upd         = '0;
      upd.en      = s1_valid_ff && advance && !s1_mode_ff && !dec.illegal;
      upd.rd      = dec.dest_reg;
      upd.rs1     = dec.src1_reg;
      upd.rs2     = instruction_rs2(s1_instr_ff);
      upd.use_rd  = dec.use_rd;
      upd.use_rs1 = dec.use_rs1;
      upd.use_rs2 = dec.use_rs2;
   end

   function automatic logic [rv64d_pkg::REG_IDX_W-1:0] instruction_rs2(input logic [31:0] w);
      return w[24:20];
   endfunction

   rv64d_use_counters u_counters (
      .clock      (clock),
      .reset      (reset),
      .upd        (upd),
      .read_index (s1_index_ff),
      .read_count (read_count)
   );

   // Result packing: a counter read or an illegal word leaves the other fields zero.
   always_comb begin
      rsp_data_in = '0;
      rsp_user_in = 1'b0;
      if (s1_mode_ff) begin
         rsp_data_in[rv64d_pkg::RSP_COUNT_LSB +: 32] = rv64d_pkg::count_to_field(read_count);
      end else if (dec.illegal) begin
         rsp_user_in = 1'b1;
      end else begin
         rsp_data_in[rv64d_pkg::RSP_CLASS_LSB +: 3] = dec.op_class;
         rsp_data_in[rv64d_pkg::RSP_MNEM_LSB  +: 7] = dec.mnemonic;
         rsp_data_in[rv64d_pkg::RSP_RD_LSB    +: 5] = dec.dest_reg;
         rsp_data_in[rv64d_pkg::RSP_RS1_LSB   +: 5] = dec.src1_reg;
         rsp_data_in[rv64d_pkg::RSP_RS2_LSB   +: 5] = dec.src2_reg;
         rsp_data_in[rv64d_pkg::RSP_IMM_LSB   +: 32] = dec.immediate;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
      if (req_xfer) begin
         s1_mode_ff  <= req_tuser;
         s1_instr_ff <= req_tdata[rv64d_pkg::REQ_INSTR_LSB +: 32];
         s1_index_ff <= req_tdata[rv64d_pkg::REQ_INDEX_LSB +: rv64d_pkg::REG_IDX_W];
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (advance && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

@@ src/rv64d_checker.sv @@
// Port-level assertions for the instruction decoder, bound to its top level.
// Depends on rv64d_pkg and the macros in assert_macros.svh.
`include "assert_macros.svh"

module rv64d_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [rv64d_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                              rsp_tuser
);

   // A stalled result stays offered.
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "result dropped while stalled")

   // Reset leaves no result pending.
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "result valid after reset")

   // An illegal word reports every field as zero.
   `ASSERT_CLK(a_illegal_zero, clock, reset, rsp_tvalid && rsp_tuser |-> rsp_tdata == '0, "illegal result carries fields")

   // A nonzero counter value only comes from a read, which carries nothing else.
   `ASSERT_CLK(a_count_alone, clock, reset, rsp_tvalid && rsp_tdata[88:57] != 32'd0 |-> rsp_tdata[56:0] == 57'd0 && !rsp_tuser, "counter read mixed with decode fields")

   // Class and mnemonic codes stay in range and the padding stays clear.
   `ASSERT_CLK(a_codes_range, clock, reset, rsp_tvalid |-> rsp_tdata[2:0] <= 3'd6 && rsp_tdata[9:3] <= 7'd71 && rsp_tdata[95:89] == 7'd0, "response code out of range")

endmodule

bind rv64im_instruction_decoder rv64d_checker u_rv64d_checker (.*);
